FILE: design/mfp_pkg.sv
// Package for the market feed message parser.
// Holds the result record, the message-type letters and the per-type field layout.
// No dependencies.
package mfp_pkg;

   localparam int NUM_TYPES  = 21;
   localparam int MAX_FIELDS = 17;

   localparam logic [1:0] KIND_TYPE  = 2'd0;
   localparam logic [1:0] KIND_INT   = 2'd1;
   localparam logic [1:0] KIND_ALPHA = 2'd2;
   localparam logic [1:0] KIND_PRICE = 2'd3;

   // layout entry: kind in [5:4], size in [3:0]
   typedef logic [5:0] entry_type;

   typedef struct packed {
      logic [7:0]  message_type;
      logic [4:0]  field_number;
      logic [1:0]  field_kind;
      logic [63:0] field_value;
      logic [3:0]  field_size;
      logic [3:0]  decimal_places;
      logic        last_field;
   } result_type;

   localparam logic [7:0] TYPE_LETTER [0:NUM_TYPES-1] = '{
      8'h53, 8'h52, 8'h48, 8'h59, 8'h4C, 8'h56, 8'h57, 8'h4B, 8'h4A, 8'h68, 8'h41,
      8'h46, 8'h45, 8'h43, 8'h58, 8'h44, 8'h55, 8'h50, 8'h51, 8'h42, 8'h49
   };

   localparam logic [4:0] FIELD_COUNT [0:NUM_TYPES-1] = '{
      5'd4, 5'd17, 5'd7, 5'd5, 5'd8, 5'd6, 5'd4, 5'd7, 5'd8, 5'd6, 5'd8,
      5'd9, 5'd6, 5'd8, 5'd5, 5'd4, 5'd7, 5'd9, 5'd8, 5'd4, 5'd12
   };

   localparam entry_type LAYOUT [0:NUM_TYPES-1][0:MAX_FIELDS-1] = '{
      '{6'h12, 6'h12, 6'h16, 6'h21, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h28, 6'h21, 6'h21, 6'h14, 6'h21, 6'h21,
        6'h22, 6'h21, 6'h21, 6'h21, 6'h21, 6'h21, 6'h14, 6'h21},
      '{6'h12, 6'h12, 6'h16, 6'h28, 6'h21, 6'h21, 6'h24, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h28, 6'h21, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h24, 6'h28, 6'h21, 6'h21, 6'h21, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h38, 6'h38, 6'h38, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h21, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h28, 6'h14, 6'h21, 6'h34, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h28, 6'h34, 6'h34, 6'h34, 6'h14, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h28, 6'h21, 6'h21, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h21, 6'h14, 6'h28, 6'h34, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h21, 6'h14, 6'h28, 6'h34, 6'h24,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h14, 6'h18, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h14, 6'h18, 6'h21, 6'h34, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h14, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h18, 6'h14, 6'h34, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h21, 6'h14, 6'h28, 6'h34, 6'h18,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h28, 6'h34, 6'h18, 6'h21, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
      '{6'h12, 6'h12, 6'h16, 6'h18, 6'h18, 6'h21, 6'h28, 6'h34, 6'h34,
        6'h34, 6'h21, 6'h21, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00}
   };

endpackage

FILE: design/mfp_parse.sv
// Parser state and per-byte step logic: message state, field position,
// byte count and big-endian accumulator. Uses mfp_pkg.
module mfp_parse
   import mfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  stream_byte,
   output logic        has_result,
   output result_type  result
);

   logic        in_message_ff, in_message_in;
   logic [4:0]  type_code_ff, type_code_in;
   logic [4:0]  field_position_ff, field_position_in;
   logic [3:0]  bytes_taken_ff, bytes_taken_in;
   logic [63:0] accumulator_ff, accumulator_in;

   logic        type_ok;
   logic [4:0]  count;
   logic        bad;
   logic        active;
   logic        found;
   logic [4:0]  match_code;
   logic [4:0]  slot;
   entry_type   entry;
   logic [1:0]  kind;
   logic [3:0]  size;
   logic [3:0]  taken_next;
   logic [63:0] acc_next;
   logic        done;
   logic        last;

   always_comb begin
      type_ok = (type_code_ff < 5'(NUM_TYPES));
      count   = type_ok ? FIELD_COUNT[type_code_ff] : 5'd0;
      bad     = in_message_ff && (!type_ok || field_position_ff == 5'd0 ||
                                  field_position_ff > count);
      active  = in_message_ff && !bad;

      found      = 1'b0;
      match_code = 5'd0;
      for (int t = 0; t < NUM_TYPES; t++) begin
         if (TYPE_LETTER[t] == stream_byte) begin
            found      = 1'b1;
            match_code = 5'(t);
         end
      end

      slot  = field_position_ff - 5'd1;
      entry = active ? LAYOUT[type_code_ff][slot] : '0;
      kind  = entry[5:4];
      size  = entry[3:0];

      acc_next   = {accumulator_ff[55:0], stream_byte};
      taken_next = bytes_taken_ff + 4'd1;
      done       = (taken_next >= size);
      last       = (field_position_ff == count);

      has_result = active ? done : found;

      if (active) begin
         result.message_type   = type_ok ? TYPE_LETTER[type_code_ff] : 8'd0;
         result.field_number   = field_position_ff;
         result.field_kind     = kind;
         result.field_value    = acc_next;
         result.field_size     = size;
         result.decimal_places = (kind == KIND_PRICE) ? size : 4'd0;
         result.last_field     = last;
      end else begin
         result.message_type   = stream_byte;
         result.field_number   = 5'd0;
         result.field_kind     = KIND_TYPE;
         result.field_value    = {56'd0, stream_byte};
         result.field_size     = 4'd1;
         result.decimal_places = 4'd0;
         result.last_field     = 1'b0;
      end

      in_message_in     = in_message_ff;
      type_code_in      = type_code_ff;
      field_position_in = field_position_ff;
      bytes_taken_in    = bytes_taken_ff;
      accumulator_in    = accumulator_ff;
      if (step) begin
         if (active) begin
            if (!done) begin
               bytes_taken_in = taken_next;
               accumulator_in = acc_next;
            end else if (last) begin
               in_message_in     = 1'b0;
               type_code_in      = 5'd0;
               field_position_in = 5'd0;
               bytes_taken_in    = 4'd0;
               accumulator_in    = 64'd0;
            end else begin
               field_position_in = field_position_ff + 5'd1;
               bytes_taken_in    = 4'd0;
               accumulator_in    = 64'd0;
            end
         end else if (found) begin
            in_message_in     = 1'b1;
            type_code_in      = match_code;
            field_position_in = 5'd1;
            bytes_taken_in    = 4'd0;
            accumulator_in    = 64'd0;
         end else begin
            in_message_in     = 1'b0;
            type_code_in      = 5'd0;
            field_position_in = 5'd0;
            bytes_taken_in    = 4'd0;
            accumulator_in    = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff     <= 1'b0;
         type_code_ff      <= 5'd0;
         field_position_ff <= 5'd0;
         bytes_taken_ff    <= 4'd0;
         accumulator_ff    <= 64'd0;
      end else begin
         in_message_ff     <= in_message_in;
         type_code_ff      <= type_code_in;
         field_position_ff <= field_position_in;
         bytes_taken_ff    <= bytes_taken_in;
         accumulator_ff    <= accumulator_in;
      end
   end

endmodule

FILE: design/market_feed_message_parser_unit.sv
// Top level of the market feed message parser: input beat register,
// parse step (mfp_parse) and result register. Uses mfp_pkg.
// An accepted req beat passes the input beat register, then the result register, to rsp_valid of its result.
// Throughput: one byte per cycle, unless a stalled, full result register holds a result-giving parse step.
// Reset: synchronous, active high; clears both beat valid flags and parser state.
module market_feed_message_parser_unit
   import mfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_message_type,
   output logic [4:0]  rsp_field_number,
   output logic [1:0]  rsp_field_kind,
   output logic [63:0] rsp_field_value,
   output logic [3:0]  rsp_field_size,
   output logic [3:0]  rsp_decimal_places,
   output logic        rsp_last_field
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       has_result;
   result_type result;
   logic       out_free;
   logic       step;
   logic       accept;

   mfp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (in_byte_ff),
      .has_result  (has_result),
      .result      (result)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      step      = in_valid_ff && (!has_result || out_free);
      req_stall = in_valid_ff && !step;
      accept    = req_valid && !req_stall;

      in_valid_in = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      in_byte_in  = accept ? req_stream_byte : in_byte_ff;

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (step && has_result) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_message_type   = out_ff.message_type;
   assign rsp_field_number   = out_ff.field_number;
   assign rsp_field_kind     = out_ff.field_kind;
   assign rsp_field_value    = out_ff.field_value;
   assign rsp_field_size     = out_ff.field_size;
   assign rsp_decimal_places = out_ff.decimal_places;
   assign rsp_last_field     = out_ff.last_field;

endmodule
